### rtl/soa_pkg.sv
// Shared types, codes and the direction table of the sonar obstacle-avoidance controller.
package soa_pkg;

  localparam int DistW  = 12;
  localparam int SpeedW = 8;
  localparam int DirW   = 3;
  localparam int PhaseW = 2;
  localparam int MsW    = 10;
  localparam int DegW   = 8;

  localparam logic [DistW-1:0]  SafeDistanceReset = 12'd30;
  localparam logic [SpeedW-1:0] MotorSpeedReset   = 8'd60;

  // Configuration register indexes.
  localparam logic REG_SAFE_DISTANCE = 1'b0;
  localparam logic REG_MOTOR_SPEED   = 1'b1;

  // Direction codes: far left is 0, far right is 6, 7 is never reached.
  localparam logic [DirW-1:0] DIR_CENTRE    = 3'd3;
  localparam logic [DirW-1:0] DIR_FAR_RIGHT = 3'd6;
  localparam logic [DirW-1:0] DIR_UNUSED    = 3'd7;
  localparam logic [DirW-1:0] DIR_LEFT_NEAR = 3'd2;

  localparam logic [PhaseW-1:0] PHASE_LEFT  = 2'd0;
  localparam logic [PhaseW-1:0] PHASE_RIGHT = 2'd2;

  // Servo actions.
  localparam logic [1:0] SERVO_NONE   = 2'd0;
  localparam logic [1:0] SERVO_SWEEP  = 2'd1;
  localparam logic [1:0] SERVO_CENTRE = 2'd2;

  localparam logic [DegW-1:0] DegCentre     = 8'd90;
  localparam logic [DegW-1:0] DegCentreLeft = 8'd120;
  localparam logic [DegW-1:0] DegScanLeft   = 8'd135;
  localparam logic [DegW-1:0] DegScanRight  = 8'd45;
  localparam logic [MsW-1:0]  MsReverse     = 10'd300;

  // Scan state carried from one reading to the next.
  typedef struct packed {
    logic [DirW-1:0]   dir;
    logic [PhaseW-1:0] phase;
  } scan_state_t;

  // One command; the first member lands in the highest bits.
  typedef struct packed {
    logic [SpeedW-1:0] drive_speed;
    logic [DirW-1:0]   new_direction;
    logic [DegW-1:0]   servo_end_deg;
    logic [DegW-1:0]   servo_start_deg;
    logic [1:0]        servo_action;
    logic              resume_forward;
    logic [MsW-1:0]    maneuver_ms;
    logic              right_wheel_dir;
    logic              left_wheel_dir;
    logic              maneuver_valid;
    logic              stop_motors;
  } cmd_t;

  typedef struct packed {
    logic [DegW-1:0] sweep_from;
    logic [DegW-1:0] sweep_to;
    logic [DirW-1:0] next_dir;
    logic            left_rev;
    logic            right_rev;
    logic [MsW-1:0]  turn_ms;
  } dir_entry_t;

  // Per-direction sweep when blocked and turn when clear.
  function automatic dir_entry_t dir_entry(input logic [DirW-1:0] dir);
    dir_entry_t e;
    e = '0;
    case (dir)
      3'd0: e = '{8'd180, 8'd60,  3'd4, 1'b1, 1'b0, 10'd660};
      3'd1: e = '{8'd150, 8'd180, 3'd0, 1'b1, 1'b0, 10'd440};
      3'd2: e = '{8'd120, 8'd150, 3'd1, 1'b1, 1'b0, 10'd220};
      3'd4: e = '{8'd60,  8'd30,  3'd5, 1'b0, 1'b1, 10'd220};
      3'd5: e = '{8'd30,  8'd0,   3'd6, 1'b0, 1'b1, 10'd440};
      3'd6: e = '{8'd0,   8'd0,   3'd2, 1'b0, 1'b1, 10'd700};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

### rtl/soa_decide.sv
// Decision logic: one reading and the scan state give one command and the next scan state.
module soa_decide import soa_pkg::*; (
  input  logic [DistW-1:0]  distance_reading,
  input  logic [DistW-1:0]  safe_distance,
  input  logic [SpeedW-1:0] motor_speed,
  input  scan_state_t       st,
  output scan_state_t       st_nxt,
  output cmd_t              cmd
);

  logic       blocked;
  dir_entry_t e;

  assign blocked = distance_reading < safe_distance;
  assign e       = dir_entry(st.dir);

  always_comb begin
    cmd             = '0;
    cmd.drive_speed = motor_speed;
    st_nxt          = st;
    case (st.dir)
      DIR_CENTRE: begin
        if (blocked) begin
          cmd.stop_motors     = 1'b1;
          cmd.servo_action    = SERVO_SWEEP;
          cmd.servo_start_deg = DegCentre;
          cmd.servo_end_deg   = DegCentreLeft;
          st_nxt.dir          = DIR_LEFT_NEAR;
          st_nxt.phase        = '0;
        end else begin
          case (st.phase)
            PHASE_LEFT: begin
              cmd.servo_action    = SERVO_SWEEP;
              cmd.servo_start_deg = DegCentre;
              cmd.servo_end_deg   = DegScanLeft;
            end
            PHASE_RIGHT: begin
              cmd.servo_action    = SERVO_SWEEP;
              cmd.servo_start_deg = DegCentre;
              cmd.servo_end_deg   = DegScanRight;
            end
            default: cmd.servo_action = SERVO_CENTRE;
          endcase
          st_nxt.phase = st.phase + 2'd1;
        end
      end
      DIR_UNUSED: ;  // unreachable code: no action, direction kept
      default: begin
        if (blocked && st.dir == DIR_FAR_RIGHT) begin
          // Cornered on every side: back straight out.
          cmd.maneuver_valid  = 1'b1;
          cmd.left_wheel_dir  = 1'b1;
          cmd.right_wheel_dir = 1'b1;
          cmd.maneuver_ms     = MsReverse;
          st_nxt.dir          = DIR_LEFT_NEAR;
        end else if (blocked) begin
          cmd.servo_action    = SERVO_SWEEP;
          cmd.servo_start_deg = e.sweep_from;
          cmd.servo_end_deg   = e.sweep_to;
          st_nxt.dir          = e.next_dir;
        end else begin
          cmd.maneuver_valid  = 1'b1;
          cmd.left_wheel_dir  = e.left_rev;
          cmd.right_wheel_dir = e.right_rev;
          cmd.maneuver_ms     = e.turn_ms;
          cmd.resume_forward  = 1'b1;
          cmd.servo_action    = SERVO_CENTRE;
          st_nxt.dir          = DIR_CENTRE;
        end
      end
    endcase
    cmd.new_direction = st_nxt.dir;
  end

endmodule

### rtl/sonar_obstacle_avoid_fsm_core.sv
// Top level of the sonar obstacle-avoidance controller: registers, handshakes and state.
//
// Channel  | Direction | Transaction carries
// ---------+-----------+-----------------------------------------------------------
// in_      | slave     | one finished distance reading (tdata[11:0])
// out_     | master    | one motor, manoeuvre and servo command per reading
// cfg_     | write     | safe_distance (index 0), motor_speed (index 1)
//
// An accepted reading passes through the input register and then the command register
// before its command appears on out_; a new reading can be accepted every cycle while
// out_ does not stall. The decision between those registers is one compare and a
// small table decode. Reset (synchronous, rst_n low) empties both stages, centres the
// probe direction, clears the scan phase and loads the register defaults. A stall on
// out_ holds the command register and backs pressure through to in_tready.
module sonar_obstacle_avoid_fsm_core import soa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // Input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // [11:0] distance_reading, [15:12] zero
  // Result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata,  // [0] stop_motors, [1] maneuver_valid,
                                          // [2] left_wheel_dir, [3] right_wheel_dir,
                                          // [13:4] maneuver_ms, [14] resume_forward,
                                          // [16:15] servo_action, [24:17] servo_start_deg,
                                          // [32:25] servo_end_deg, [35:33] new_direction,
                                          // [43:36] drive_speed, [47:44] zero
  // Configuration writes
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [DistW-1:0]    cfg_wdata
);

  logic [DistW-1:0]  safe_distance_r;
  logic [SpeedW-1:0] motor_speed_r;

  logic              in_valid_r;
  logic [DistW-1:0]  dist_r;
  logic              out_valid_r;
  cmd_t              cmd_r;
  scan_state_t       st_r;

  scan_state_t       st_nxt;
  cmd_t              cmd_nxt;
  logic              in_fire;
  logic              stage_adv;

  // The reading in the input register moves on whenever the command register is free
  // or is being emptied in the same cycle; the scan state is updated at that moment.
  assign stage_adv = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || stage_adv;
  assign in_fire   = in_tvalid && in_tready;

  soa_decide u_decide (
    .distance_reading (dist_r),
    .safe_distance    (safe_distance_r),
    .motor_speed      (motor_speed_r),
    .st               (st_r),
    .st_nxt           (st_nxt),
    .cmd              (cmd_nxt)
  );

  // Configuration registers. The user must write only while the pipeline is empty; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_distance_r <= SafeDistanceReset;
      motor_speed_r   <= MotorSpeedReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SAFE_DISTANCE: safe_distance_r <= cfg_wdata;
        REG_MOTOR_SPEED:   motor_speed_r   <= cfg_wdata[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // Control state: stage valid flags and the scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{dir: DIR_CENTRE, phase: '0};
    end else begin
      if (in_fire)
        in_valid_r <= 1'b1;
      else if (stage_adv)
        in_valid_r <= 1'b0;

      if (stage_adv)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;

      if (stage_adv)
        st_r <= st_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_fire)
      dist_r <= in_tdata[DistW-1:0];
    if (stage_adv)
      cmd_r <= cmd_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, cmd_r};

  // The probe direction never takes the unused code.
  a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.dir != DIR_UNUSED)
    else $error("probe direction reached the unused code");

  // The scan state only moves when a reading passes into the command register.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !stage_adv |=> $stable(st_r))
    else $error("scan state changed without a reading being decided");

  // A command with no manoeuvre carries no wheel directions and no duration.
  a_idle_wheels: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !cmd_r.maneuver_valid) |->
      (cmd_r.maneuver_ms == '0 && !cmd_r.left_wheel_dir && !cmd_r.right_wheel_dir))
    else $error("wheel fields set without a manoeuvre");

  // The reported direction is the state left behind by the latest decided reading.
  a_dir_reported: assert property (@(posedge clk) disable iff (!rst_n)
    stage_adv |=> (cmd_r.new_direction == st_r.dir))
    else $error("reported direction disagrees with the scan state");

endmodule
